// ===== sv/pfd_pkg.sv =====
// shared constants, command and status types and the arctangent table of the pose frame decoder
package pfd_pkg;

  localparam int ASIN_ITER_DEF = 16;
  localparam int ATAN_LEN      = 24;
  localparam int IDXW          = 5;
  localparam int SQ_STEPS      = 28;
  localparam int VW            = 13;
  localparam int AW            = 15;
  localparam int SPW           = 12;
  localparam int CFG_IW        = 2;
  localparam int CFG_DW        = 12;

  localparam logic [7:0] START_BYTE = 8'h41;
  localparam logic [7:0] MARK_BYTE  = 8'h42;
  localparam logic [7:0] MINUS_BYTE = 8'h2D;
  localparam logic [3:0] LAST_POS   = 4'd15;

  localparam logic [CFG_IW-1:0] REG_SPAN_AC = 2'd0;
  localparam logic [CFG_IW-1:0] REG_SPAN_BD = 2'd1;

  localparam logic [SPW-1:0] SPAN_AC_RST = 12'd318;
  localparam logic [SPW-1:0] SPAN_BD_RST = 12'd258;

  typedef struct packed {
    logic            wr_en;
    logic [3:0]      wr_pos;
    logic            decode;
    logic            sel_bd;
    logic            prep;
    logic            square;
    logic            sqrt_load;
    logic            sqrt_step;
    logic            cordic_load;
    logic            cordic_step;
    logic [IDXW-1:0] cnt;
    logic            finish;
  } pfd_cmd_t;

  typedef struct packed {
    logic is_start;
    logic mark_ok;
    logic special;
  } pfd_stat_t;

  // atan(2^-i) in 1/65536 of a hundredth of a degree
  function automatic logic [31:0] atan_entry(input logic [IDXW-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'd294912000;
      5'd1:    v = 32'd174096719;
      5'd2:    v = 32'd91987925;
      5'd3:    v = 32'd46694507;
      5'd4:    v = 32'd23437865;
      5'd5:    v = 32'd11730358;
      5'd6:    v = 32'd5866610;
      5'd7:    v = 32'd2933484;
      5'd8:    v = 32'd1466764;
      5'd9:    v = 32'd733385;
      5'd10:   v = 32'd366693;
      5'd11:   v = 32'd183347;
      5'd12:   v = 32'd91673;
      5'd13:   v = 32'd45837;
      5'd14:   v = 32'd22918;
      5'd15:   v = 32'd11459;
      5'd16:   v = 32'd5730;
      5'd17:   v = 32'd2865;
      5'd18:   v = 32'd1432;
      5'd19:   v = 32'd716;
      5'd20:   v = 32'd358;
      5'd21:   v = 32'd179;
      5'd22:   v = 32'd90;
      5'd23:   v = 32'd45;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/pfd_asin.sv =====
// iterative arcsine unit: squares, digit-by-digit square root and vectoring cordic
module pfd_asin (
  input  logic                       clk,
  input  pfd_pkg::pfd_cmd_t          cmd,
  input  logic signed [13:0]         diff_i,
  input  logic [pfd_pkg::SPW-1:0]    span_i,
  input  logic                       negate_i,
  output logic signed [pfd_pkg::AW-1:0] angle_o,
  output logic                       clip_o,
  output logic                       special_o
);
  import pfd_pkg::*;

  localparam int SQW    = 57;
  localparam int SQ_TOP = 54;
  localparam int CW     = 34;
  localparam logic signed [31:0] ZMAX  = 32'sd589824000;
  localparam logic signed [31:0] RHALF = 32'sd32768;
  localparam logic [13:0]        A_FULL = 14'd9000;

  logic [12:0]           mag_r;
  logic [SPW-1:0]        sp_r;
  logic                  neg_r;
  logic [23:0]           sp2_r;
  logic [23:0]           mag2_r;
  logic [SQW-1:0]        v_r, res_r, bit_r;
  logic signed [CW-1:0]  x_r, y_r;
  logic signed [31:0]    z_r;

  logic [13:0]           diff_abs;
  logic [23:0]           rad;
  logic [SQW-1:0]        sq_sum;
  logic signed [CW-1:0]  xs, ys;
  logic signed [31:0]    tab;
  logic signed [31:0]    zc, rsum;
  logic [13:0]           a_mag;
  logic [AW-1:0]         a_ext;

  assign diff_abs = diff_i[13] ? 14'(-diff_i) : diff_i;
  assign rad      = sp2_r - mag2_r;
  assign sq_sum   = res_r + bit_r;
  assign xs       = x_r >>> cmd.cnt;
  assign ys       = y_r >>> cmd.cnt;
  assign tab      = $signed(atan_entry(cmd.cnt));

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      mag_r <= diff_abs[12:0];
      sp_r  <= (span_i == '0) ? SPW'(1) : span_i;
      neg_r <= diff_i[13] ^ negate_i;
    end
    if (cmd.square) begin
      // only read when the magnitude is below the span, so 24 bits hold both squares
      sp2_r  <= 24'(sp_r) * 24'(sp_r);
      mag2_r <= 24'(mag_r) * 24'(mag_r);
    end
    if (cmd.sqrt_load) begin
      v_r   <= {1'b0, rad, 32'd0};
      res_r <= '0;
      bit_r <= SQW'(1) << SQ_TOP;
    end
    if (cmd.sqrt_step) begin
      if (v_r >= sq_sum) begin
        v_r   <= v_r - sq_sum;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.cordic_load) begin
      x_r <= $signed({6'd0, res_r[27:0]});
      y_r <= $signed({5'd0, mag_r, 16'd0});
      z_r <= '0;
    end
    if (cmd.cordic_step) begin
      if (y_r > 0) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + tab;
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - tab;
      end
    end
  end

  // clamp, round half up, then pick the special cases and apply the sign
  always_comb begin
    if (z_r < 0)
      zc = '0;
    else if (z_r > ZMAX)
      zc = ZMAX;
    else
      zc = z_r;
    rsum = zc + RHALF;
    if (mag_r == '0)
      a_mag = '0;
    else if (mag_r >= {1'b0, sp_r})
      a_mag = A_FULL;
    else
      a_mag = rsum[29:16];
    a_ext   = {1'b0, a_mag};
    angle_o = neg_r ? $signed(AW'(-a_ext)) : $signed(a_ext);
  end

  assign clip_o    = mag_r > {1'b0, sp_r};
  assign special_o = (mag_r == '0) || (mag_r >= {1'b0, sp_r});

endmodule

// ===== sv/pfd_datapath.sv =====
// datapath: configuration registers, frame store, value decode, result registers
module pfd_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [pfd_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [pfd_pkg::CFG_DW-1:0]    cfg_data,
  input  logic [7:0]                    in_rx_byte,
  input  pfd_pkg::pfd_cmd_t             cmd,
  output pfd_pkg::pfd_stat_t            stat,
  output logic signed [pfd_pkg::VW-1:0] out_value_a,
  output logic signed [pfd_pkg::VW-1:0] out_value_b,
  output logic signed [pfd_pkg::VW-1:0] out_value_c,
  output logic signed [pfd_pkg::VW-1:0] out_value_d,
  output logic signed [pfd_pkg::VW-1:0] out_pos_x,
  output logic signed [pfd_pkg::VW-1:0] out_pos_y,
  output logic signed [pfd_pkg::AW-1:0] out_angle_ac,
  output logic signed [pfd_pkg::AW-1:0] out_angle_bd,
  output logic                          out_ratio_clipped
);
  import pfd_pkg::*;

  logic [SPW-1:0]       span_ac_r, span_bd_r;
  logic [7:0]           frame_r [16];
  logic signed [VW-1:0] a_r, b_r, c_r, d_r, px_r, py_r;
  logic signed [AW-1:0] ang_ac_r, ang_bd_r;
  logic                 clip_r;

  logic signed [VW-1:0] a_dec, b_dec, c_dec, d_dec;
  logic signed [13:0]   diff;
  logic signed [AW-1:0] angle;
  logic                 clip, special;

  function automatic logic signed [VW-1:0] decode_value(input logic [7:0] sgn,
                                                         input logic [7:0] d1,
                                                         input logic [7:0] d0);
    logic [VW-1:0] m;
    m = ({5'd0, d1} << 3) + ({5'd0, d1} << 1) + {5'd0, d0};
    return (sgn == MINUS_BYTE) ? $signed(VW'(-m)) : $signed(m);
  endfunction

  // (p + q) / 2 truncated toward zero
  function automatic logic signed [VW-1:0] half_sum(input logic signed [VW-1:0] p,
                                                     input logic signed [VW-1:0] q);
    logic signed [VW:0] s;
    logic signed [VW:0] h;
    s = {p[VW-1], p} + {q[VW-1], q};
    h = (s + $signed({{VW{1'b0}}, s[VW]})) >>> 1;
    return h[VW-1:0];
  endfunction

  assign a_dec = decode_value(frame_r[1],  frame_r[2],  frame_r[3]);
  assign b_dec = decode_value(frame_r[5],  frame_r[6],  frame_r[7]);
  assign c_dec = decode_value(frame_r[9],  frame_r[10], frame_r[11]);
  assign d_dec = decode_value(frame_r[13], frame_r[14], frame_r[15]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_ac_r <= SPAN_AC_RST;
      span_bd_r <= SPAN_BD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SPAN_AC: span_ac_r <= cfg_data;
        REG_SPAN_BD: span_bd_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en)
      frame_r[cmd.wr_pos] <= in_rx_byte;
    if (cmd.decode) begin
      a_r    <= a_dec;
      b_r    <= b_dec;
      c_r    <= c_dec;
      d_r    <= d_dec;
      px_r   <= half_sum(a_dec, c_dec);
      py_r   <= half_sum(b_dec, d_dec);
      clip_r <= 1'b0;
    end
    if (cmd.finish) begin
      if (cmd.sel_bd)
        ang_bd_r <= angle;
      else
        ang_ac_r <= angle;
      clip_r <= clip_r | clip;
    end
  end

  assign diff = cmd.sel_bd ? ({b_r[VW-1], b_r} - {d_r[VW-1], d_r})
                           : ({a_r[VW-1], a_r} - {c_r[VW-1], c_r});

  pfd_asin u_asin (
    .clk       (clk),
    .cmd       (cmd),
    .diff_i    (diff),
    .span_i    (cmd.sel_bd ? span_bd_r : span_ac_r),
    .negate_i  (~cmd.sel_bd),
    .angle_o   (angle),
    .clip_o    (clip),
    .special_o (special)
  );

  assign stat.is_start = (in_rx_byte == START_BYTE);
  assign stat.mark_ok  = (frame_r[4] == MARK_BYTE);
  assign stat.special  = special;

  assign out_value_a       = a_r;
  assign out_value_b       = b_r;
  assign out_value_c       = c_r;
  assign out_value_d       = d_r;
  assign out_pos_x         = px_r;
  assign out_pos_y         = py_r;
  assign out_angle_ac      = ang_ac_r;
  assign out_angle_bd      = ang_bd_r;
  assign out_ratio_clipped = clip_r;

endmodule

// ===== sv/pfd_ctrl.sv =====
// controller: frame collector position, angle sequencing and output valid
module pfd_ctrl #(
  parameter int ASIN_ITERATIONS = pfd_pkg::ASIN_ITER_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  pfd_pkg::pfd_stat_t stat,
  output pfd_pkg::pfd_cmd_t  cmd
);
  import pfd_pkg::*;

  localparam int N_EFF = (ASIN_ITERATIONS > ATAN_LEN) ? ATAN_LEN : ASIN_ITERATIONS;
  localparam logic [IDXW-1:0] CORDIC_LAST = IDXW'(N_EFF - 1);
  localparam logic [IDXW-1:0] SQRT_LAST   = IDXW'(SQ_STEPS - 1);

  typedef enum logic [3:0] {
    S_COLLECT, S_DECODE, S_PREP, S_SQUARE, S_LOAD,
    S_SQRT, S_CINIT, S_CORDIC, S_FINISH
  } state_t;

  state_t          state_r;
  logic [3:0]      pos_r;
  logic [IDXW-1:0] cnt_r;
  logic            sel_r;
  logic            out_valid_r;
  logic            in_acc;

  assign in_stall = (state_r != S_COLLECT) || (out_valid_r && (pos_r == LAST_POS));
  assign in_acc   = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_COLLECT;
      pos_r       <= '0;
      cnt_r       <= '0;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall)
        out_valid_r <= 1'b0;
      case (state_r)
        S_COLLECT: begin
          if (in_acc) begin
            if (pos_r == '0) begin
              pos_r <= stat.is_start ? 4'd1 : 4'd0;
            end else if (pos_r == LAST_POS) begin
              pos_r <= '0;
              if (stat.mark_ok)
                state_r <= S_DECODE;
            end else begin
              pos_r <= pos_r + 4'd1;
            end
          end
        end
        S_DECODE: begin
          sel_r   <= 1'b0;
          state_r <= S_PREP;
        end
        S_PREP:   state_r <= S_SQUARE;
        S_SQUARE: state_r <= S_LOAD;
        S_LOAD: begin
          cnt_r   <= '0;
          state_r <= stat.special ? S_FINISH : S_SQRT;
        end
        S_SQRT: begin
          if (cnt_r == SQRT_LAST) begin
            cnt_r   <= '0;
            state_r <= S_CINIT;
          end else begin
            cnt_r <= cnt_r + IDXW'(1);
          end
        end
        S_CINIT: state_r <= S_CORDIC;
        S_CORDIC: begin
          if (cnt_r == CORDIC_LAST) begin
            cnt_r   <= '0;
            state_r <= S_FINISH;
          end else begin
            cnt_r <= cnt_r + IDXW'(1);
          end
        end
        S_FINISH: begin
          if (!sel_r) begin
            sel_r   <= 1'b1;
            state_r <= S_PREP;
          end else begin
            out_valid_r <= 1'b1;
            state_r     <= S_COLLECT;
          end
        end
        default: state_r <= S_COLLECT;
      endcase
    end
  end

  always_comb begin
    cmd             = '0;
    cmd.wr_en       = (state_r == S_COLLECT) && in_acc;
    cmd.wr_pos      = pos_r;
    cmd.decode      = (state_r == S_DECODE);
    cmd.sel_bd      = sel_r;
    cmd.prep        = (state_r == S_PREP);
    cmd.square      = (state_r == S_SQUARE);
    cmd.sqrt_load   = (state_r == S_LOAD);
    cmd.sqrt_step   = (state_r == S_SQRT);
    cmd.cordic_load = (state_r == S_CINIT);
    cmd.cordic_step = (state_r == S_CORDIC);
    cmd.cnt         = cnt_r;
    cmd.finish      = (state_r == S_FINISH);
  end

  // a new result only appears after the second angle is finished
  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FINISH && sel_r))
    else $error("output valid rose outside the final step");

  // leaving the collector only follows the last byte of a frame
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECODE) |-> $past(state_r == S_COLLECT && pos_r == LAST_POS && in_acc))
    else $error("decode entered without a completed frame");

  // a frame may only complete when the result register is free
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECODE) |-> !out_valid_r)
    else $error("frame decoded while previous result still pending");

  // cordic index never runs past the table
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CORDIC) |-> (cnt_r <= CORDIC_LAST))
    else $error("cordic step index out of range");

endmodule

// ===== sv/pose_frame_decoder_top.sv =====
// top level of the pose frame decoder: byte collector, value decode and arcsine angles
//
//  channel  direction  handshake            payload
//  in_      input      in_valid / in_stall  in_rx_byte (8 bit)
//  out_     output     out_valid/out_stall  value_a..d, pos_x/y, angle_ac/bd, ratio_clipped
//  cfg_     input      cfg_we               cfg_index (2 bit), cfg_data (12 bit)
//
// a byte is accepted whenever in_valid is high and in_stall is low; the last byte of a
// good frame starts the decode, which holds off input while both angles are computed
// in turn by the shared square root and cordic unit
// a difference of zero or at least the span skips the square root and cordic
// synchronous active-low reset clears the controller and presets the span registers
// the result stays in its register until taken; bytes of the next frame are accepted
// meanwhile, and only the last byte of a frame waits for the result register to free
module pose_frame_decoder_top #(
  parameter int ASIN_ITERATIONS = pfd_pkg::ASIN_ITER_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [pfd_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [pfd_pkg::CFG_DW-1:0]    cfg_data,
  // byte input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_rx_byte,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [pfd_pkg::VW-1:0] out_value_a,
  output logic signed [pfd_pkg::VW-1:0] out_value_b,
  output logic signed [pfd_pkg::VW-1:0] out_value_c,
  output logic signed [pfd_pkg::VW-1:0] out_value_d,
  output logic signed [pfd_pkg::VW-1:0] out_pos_x,
  output logic signed [pfd_pkg::VW-1:0] out_pos_y,
  output logic signed [pfd_pkg::AW-1:0] out_angle_ac,
  output logic signed [pfd_pkg::AW-1:0] out_angle_bd,
  output logic                          out_ratio_clipped
);
  import pfd_pkg::*;

  // command and status between controller and datapath
  pfd_cmd_t  cmd;
  pfd_stat_t stat;

  // controller: frame position, sequencing of both angles, result valid
  pfd_ctrl #(
    .ASIN_ITERATIONS (ASIN_ITERATIONS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: spans, frame store, decoded values and angle unit
  pfd_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_rx_byte        (in_rx_byte),
    .cmd               (cmd),
    .stat              (stat),
    .out_value_a       (out_value_a),
    .out_value_b       (out_value_b),
    .out_value_c       (out_value_c),
    .out_value_d       (out_value_d),
    .out_pos_x         (out_pos_x),
    .out_pos_y         (out_pos_y),
    .out_angle_ac      (out_angle_ac),
    .out_angle_bd      (out_angle_bd),
    .out_ratio_clipped (out_ratio_clipped)
  );

endmodule
